[design/cds_pkg.sv]
// ----------------------------------------------------------------------------
// Card deck shuffle and deal: shared definitions
// Opcodes, status codes, field widths and the request and response types of
// the modulo unit.
// ----------------------------------------------------------------------------
package cds_pkg;

	// Field widths of the input and result beats.
	localparam int OP_W     = 3;
	localparam int RANK_W   = 4;
	localparam int SUIT_W   = 2;
	localparam int CARD_W   = RANK_W + SUIT_W;
	localparam int IDX_W    = 6;
	localparam int RND_W    = 31;
	localparam int STATUS_W = 2;

	// Deck capacity and default deck geometry.
	localparam int DECK_CAP           = 52;
	localparam int DEFAULT_RANK_COUNT = 13;
	localparam int DEFAULT_SUIT_COUNT = 4;

	// Opcodes.
	localparam logic [OP_W-1:0] OP_MARK       = 3'd0;
	localparam logic [OP_W-1:0] OP_BUILD      = 3'd1;
	localparam logic [OP_W-1:0] OP_DEAL       = 3'd2;
	localparam logic [OP_W-1:0] OP_SHUF_BEGIN = 3'd3;
	localparam logic [OP_W-1:0] OP_SHUF_STEP  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DEAL_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SHUF_DONE  = 2'd2;

	// Request to the modulo unit.
	typedef struct packed {
		logic             start;
		logic [RND_W-1:0] dividend;
		logic [IDX_W-1:0] divisor;
	} mod_req_t;

	// Response from the modulo unit.
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] remainder;
	} mod_rsp_t;

endpackage

[design/cds_mod_unit.sv]
// ----------------------------------------------------------------------------
// Card deck shuffle and deal: modulo unit
// Restoring division, one dividend bit per cycle, that returns the
// remainder of a random word by a small divisor.
// ----------------------------------------------------------------------------
module cds_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  cds_pkg::mod_req_t req,
	output cds_pkg::mod_rsp_t rsp
);
	import cds_pkg::*;

	localparam int STEP_W = $clog2(RND_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0]  dvd_q;
	logic [IDX_W-1:0]  dvs_q;
	logic [IDX_W:0]    rem_q;
	logic [IDX_W:0]    rem_sh;
	logic [IDX_W:0]    rem_nx;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign rem_sh = {rem_q[IDX_W-1:0], dvd_q[RND_W-1]};
	assign rem_nx = (rem_sh >= {1'b0, dvs_q}) ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(RND_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifter and partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q[IDX_W-1:0];

endmodule

[design/card_deck_shuffle_deal.sv]
// ----------------------------------------------------------------------------
// Card deck shuffle and deal
// Deck store with exclusion marks, deck build, deal from the back and a
// Fisher-Yates shuffle performed one swap per input beat.
// ----------------------------------------------------------------------------
// The deck lives in a 52-entry synchronous memory with one read and one write
// port. One input beat is handled at a time. A mark, shuffle begin, failed or
// empty deal, or unknown opcode yields a single result beat. A build walks
// every (rank, suit) pair once. A deal of n cards reads each card from the
// memory and then sends it as a result beat. A shuffle step that still has a
// swap to do first waits on the bit-serial modulo unit, then does two reads
// and two writes of the memory. Stalls on the result side hold the sequencer.
// The next beat is taken while the final result of the previous one still
// waits in the output register.
// ----------------------------------------------------------------------------
module card_deck_shuffle_deal #(
	parameter int RANK_COUNT = cds_pkg::DEFAULT_RANK_COUNT,
	parameter int SUIT_COUNT = cds_pkg::DEFAULT_SUIT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cds_pkg::OP_W-1:0]      opcode,
	input  logic [cds_pkg::RANK_W-1:0]    card_rank,
	input  logic [cds_pkg::SUIT_W-1:0]    card_suit,
	input  logic [cds_pkg::IDX_W-1:0]     deal_count,
	input  logic [cds_pkg::RND_W-1:0]     random_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cds_pkg::STATUS_W-1:0]  status,
	output logic                          card_valid,
	output logic [cds_pkg::RANK_W-1:0]    out_rank,
	output logic [cds_pkg::SUIT_W-1:0]    out_suit,
	output logic                          last,
	output logic [cds_pkg::IDX_W-1:0]     deck_size,
	output logic                          shuffle_done
);
	import cds_pkg::*;

	localparam int MASK_EXT_W = 2 ** IDX_W;
	localparam int BIT_W      = 8;

	// Sequencer states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RESP    = 4'd1;
	localparam logic [3:0] S_BUILD   = 4'd2;
	localparam logic [3:0] S_DEAL_RD = 4'd3;
	localparam logic [3:0] S_DEAL_WT = 4'd4;
	localparam logic [3:0] S_DIV     = 4'd5;
	localparam logic [3:0] S_SW_RDI  = 4'd6;
	localparam logic [3:0] S_SW_RDJ  = 4'd7;
	localparam logic [3:0] S_SW_WI   = 4'd8;
	localparam logic [3:0] S_SW_WJ   = 4'd9;

	// Bit position of a card in the exclusion mask, wide enough not to wrap.
	function automatic logic [BIT_W-1:0] card_bit(input logic [RANK_W-1:0] r,
			input logic [SUIT_W-1:0] s);
		return BIT_W'(r) * BIT_W'(SUIT_COUNT) + BIT_W'(s);
	endfunction

	logic [3:0]          state_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    remaining_q;
	logic [IDX_W-1:0]    swap_q;
	logic [DECK_CAP-1:0] mask_q;
	logic [RANK_W-1:0]   brank_q;
	logic [SUIT_W-1:0]   bsuit_q;
	logic [IDX_W-1:0]    fill_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    left_q;
	logic [IDX_W-1:0]    j_q;
	logic [CARD_W-1:0]   tmp_q;

	// Deck memory and its ports.
	logic [CARD_W-1:0]   deck_mem [DECK_CAP];
	logic [CARD_W-1:0]   mem_rdata_q;
	logic [IDX_W-1:0]    mem_raddr;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [CARD_W-1:0]   mem_wdata;

	// Output register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_card_q;
	logic [RANK_W-1:0]   out_rank_q;
	logic [SUIT_W-1:0]   out_suit_q;
	logic                out_last_q;
	logic [IDX_W-1:0]    out_size_q;
	logic                out_done_q;

	logic                slot_free;
	logic                accept;
	logic [BIT_W-1:0]    mark_bit;
	logic                mark_ok;
	logic [MASK_EXT_W-1:0] mask_ext;
	logic [BIT_W-1:0]    build_bit;
	logic                build_place;
	logic                build_end;
	logic                swap_ok;
	mod_req_t            mod_req;
	mod_rsp_t            mod_rsp;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;

	// Mark decode: out-of-range cards are ignored.
	assign mark_bit = card_bit(card_rank, card_suit);
	assign mark_ok  = ({1'b0, card_rank} < (RANK_W + 1)'(RANK_COUNT))
			&& ({1'b0, card_suit} < (SUIT_W + 1)'(SUIT_COUNT))
			&& (mark_bit < BIT_W'(DECK_CAP));

	// Build walk: one (rank, suit) pair per cycle.
	assign mask_ext    = {{(MASK_EXT_W - DECK_CAP){1'b0}}, mask_q};
	assign build_bit   = card_bit(brank_q, bsuit_q);
	assign build_place = !mask_ext[build_bit[IDX_W-1:0]] && (fill_q < IDX_W'(DECK_CAP));
	assign build_end   = (brank_q == RANK_W'(RANK_COUNT - 1))
			&& (bsuit_q == SUIT_W'(SUIT_COUNT - 1));

	// A swap is possible while the swap position is nonzero and below the deck capacity.
	assign swap_ok = (swap_q != '0) && (swap_q < IDX_W'(DECK_CAP));

	// Modulo unit request for a shuffle step.
	assign mod_req.start    = accept && (opcode == OP_SHUF_STEP) && swap_ok;
	assign mod_req.dividend = random_value;
	assign mod_req.divisor  = swap_q + 1'b1;

	cds_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Memory port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q;
		mem_wdata = {brank_q, bsuit_q};
		mem_raddr = idx_q;
		unique case (state_q)
			S_BUILD: begin
				mem_we = build_place;
			end
			S_SW_RDI: begin
				mem_raddr = swap_q;
			end
			S_SW_RDJ: begin
				mem_raddr = j_q;
			end
			S_SW_WI: begin
				mem_we    = 1'b1;
				mem_waddr = swap_q;
				mem_wdata = mem_rdata_q;
			end
			S_SW_WJ: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = tmp_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Deck memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			deck_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= deck_mem[mem_raddr];
	end

	// Sequencer and deck state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			remaining_q <= '0;
			swap_q      <= '0;
			mask_q      <= '0;
			brank_q     <= '0;
			bsuit_q     <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			left_q      <= '0;
			j_q         <= '0;
			tmp_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						status_q <= ST_OK;
						state_q  <= S_RESP;
						unique case (opcode)
							OP_MARK: begin
								if (mark_ok) begin
									mask_q <= mask_q
											| (DECK_CAP'(1) << mark_bit[IDX_W-1:0]);
								end
							end
							OP_BUILD: begin
								brank_q <= '0;
								bsuit_q <= '0;
								fill_q  <= '0;
								state_q <= S_BUILD;
							end
							OP_DEAL: begin
								if (deal_count > remaining_q) begin
									status_q <= ST_DEAL_SHORT;
								end else if (deal_count != '0) begin
									remaining_q <= remaining_q - deal_count;
									swap_q      <= '0;
									idx_q       <= remaining_q - 1'b1;
									left_q      <= deal_count;
									state_q     <= S_DEAL_RD;
								end
							end
							OP_SHUF_BEGIN: begin
								swap_q <= (remaining_q != '0) ? (remaining_q - 1'b1) : '0;
							end
							OP_SHUF_STEP: begin
								if (swap_ok) begin
									state_q <= S_DIV;
								end else begin
									status_q <= ST_SHUF_DONE;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_BUILD: begin
					if (build_place) begin
						fill_q <= fill_q + 1'b1;
					end
					if (build_end) begin
						remaining_q <= fill_q + IDX_W'(build_place);
						mask_q      <= '0;
						swap_q      <= '0;
						state_q     <= S_RESP;
					end else if (bsuit_q == SUIT_W'(SUIT_COUNT - 1)) begin
						bsuit_q <= '0;
						brank_q <= brank_q + 1'b1;
					end else begin
						bsuit_q <= bsuit_q + 1'b1;
					end
				end
				S_DEAL_RD: begin
					state_q <= S_DEAL_WT;
				end
				S_DEAL_WT: begin
					if (slot_free) begin
						if (left_q == IDX_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							left_q  <= left_q - 1'b1;
							state_q <= S_DEAL_RD;
						end
					end
				end
				S_DIV: begin
					if (mod_rsp.done) begin
						j_q     <= mod_rsp.remainder;
						state_q <= S_SW_RDI;
					end
				end
				S_SW_RDI: begin
					state_q <= S_SW_RDJ;
				end
				S_SW_RDJ: begin
					tmp_q   <= mem_rdata_q;
					state_q <= S_SW_WI;
				end
				S_SW_WI: begin
					state_q <= S_SW_WJ;
				end
				S_SW_WJ: begin
					swap_q  <= swap_q - 1'b1;
					state_q <= S_RESP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: loads one result beat when the slot is free and a result is due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_card_q   <= 1'b0;
			out_rank_q   <= '0;
			out_suit_q   <= '0;
			out_last_q   <= 1'b0;
			out_size_q   <= '0;
			out_done_q   <= 1'b0;
		end else if (slot_free && (state_q == S_RESP)) begin
			out_valid_q  <= 1'b1;
			out_status_q <= status_q;
			out_card_q   <= 1'b0;
			out_rank_q   <= '0;
			out_suit_q   <= '0;
			out_last_q   <= 1'b1;
			out_size_q   <= remaining_q;
			out_done_q   <= (swap_q == '0);
		end else if (slot_free && (state_q == S_DEAL_WT)) begin
			out_valid_q  <= 1'b1;
			out_status_q <= ST_OK;
			out_card_q   <= 1'b1;
			out_rank_q   <= mem_rdata_q[CARD_W-1:SUIT_W];
			out_suit_q   <= mem_rdata_q[SUIT_W-1:0];
			out_last_q   <= (left_q == IDX_W'(1));
			out_size_q   <= remaining_q;
			out_done_q   <= (swap_q == '0);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign card_valid   = out_card_q;
	assign out_rank     = out_rank_q;
	assign out_suit     = out_suit_q;
	assign last         = out_last_q;
	assign deck_size    = out_size_q;
	assign shuffle_done = out_done_q;

	// The deck never holds more cards than the memory has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= IDX_W'(DECK_CAP))
	else $error("deck size exceeds capacity");

	// The modulo unit only reports back while a shuffle step waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> (state_q == S_DIV))
	else $error("modulo result arrived outside a shuffle step");

	// A deal only reads entries that lie at or above the new deck size.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DEAL_RD) || (state_q == S_DEAL_WT))
			|-> ((idx_q >= remaining_q) && (left_q != '0)))
	else $error("deal pointer left the dealt range");

	// The swap partner never lies above the swap position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SW_RDI) |-> (j_q <= swap_q))
	else $error("swap partner out of range");

endmodule
